FILE: rtl/pf_pkg.sv
`default_nettype none
package pf_pkg;

   // pixel width and fixed field widths
   localparam int COORD_WIDTH = 16;
   localparam int PT_W   = 16;                 // Q8.8 point coordinate
   localparam int CF_W   = 16;                 // one matrix coefficient
   localparam int PROD_W = 2 * CF_W;           // point times extrinsic coefficient
   localparam int H_W    = 34;                 // transform sum h0..h3
   localparam int KP_W   = H_W + CF_W;         // h times intrinsic coefficient
   localparam int K_W    = KP_W + 1;           // intrinsic sum U, V, D
   localparam int NUM_W  = K_W + 1;            // twice the magnitude of U or V
   localparam int DEN_W  = K_W;                // magnitude of D
   localparam int NEAR_W = K_W + 4;            // 10*D and 16*w
   localparam int NSTEP  = COORD_WIDTH + 1;    // quotient bits of floor(2|n|/|d|)
   localparam int CMP_W  = DEN_W + NSTEP + 1;  // divider compare width
   localparam int DIV_LAT = NSTEP + 2;         // overflow stage, steps, round stage
   localparam int BOX_W  = ((COORD_WIDTH > 17) ? COORD_WIDTH : 17) + 1;
   localparam int XF_LAT = 2;
   localparam int IN_LAT = 3;
   localparam int PIPE_LAT = XF_LAT + IN_LAT + DIV_LAT;
   localparam int REQ_W  = 3 * PT_W;
   localparam int RSP_BITS = 3 + 2 * COORD_WIDTH + 3 * PT_W;
   localparam int RSP_W  = ((RSP_BITS + 7) / 8) * 8;

   typedef logic signed [PT_W-1:0]        coord_type;
   typedef logic signed [CF_W-1:0]        coef_type;
   typedef logic signed [H_W-1:0]         hval_type;
   typedef logic signed [COORD_WIDTH-1:0] pix_type;

   typedef enum logic [2:0] {
      V_INSIDE  = 3'd0,
      V_BEHIND  = 3'd1,
      V_ZERO_W  = 3'd2,
      V_NEAR    = 3'd3,
      V_OUTSIDE = 3'd4
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_EXT0  = 3'd0,
      CSR_EXT1  = 3'd1,
      CSR_EXT2  = 3'd2,
      CSR_EXT3  = 3'd3,
      CSR_INT0  = 3'd4,
      CSR_INT1  = 3'd5,
      CSR_INT2  = 3'd6,
      CSR_BOX   = 3'd7
   } csr_index_type;

   // divider operands and early flags from the intrinsic stage
   typedef struct packed {
      logic [NUM_W-1:0] num_u;
      logic [NUM_W-1:0] num_v;
      logic [DEN_W-1:0] den;
      logic             neg_u;
      logic             neg_v;
      logic             dz;
      logic             near;
      logic             zero_w;
   } prep_type;

   typedef struct packed {
      logic      behind;
      logic      zero_w;
      logic      near;
      coord_type x;
      coord_type y;
      coord_type z;
   } side_type;

endpackage
`default_nettype wire

FILE: rtl/pf_xform.sv
`default_nettype none
module pf_xform (
   input  logic              clock,
   input  logic              en,
   input  pf_pkg::coord_type pt [3],
   input  logic [63:0]       ext [4],
   output pf_pkg::hval_type  h [4]
);
   import pf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PROD_W-1:0] prod_in [4][4];
   hval_type                 h_ff [4];
   hval_type                 h_in [4];

   // point times coefficient; the weight slot is a shift by 8
   always_comb begin
      coef_type c;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            c = $signed(ext[i][16*j +: 16]);
            if (j == 3) begin
               prod_in[i][j] = {{8{c[CF_W-1]}}, c, 8'd0};
            end else begin
               prod_in[i][j] = c * pt[j];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         h_in[i] = H_W'(prod_ff[i][0]) + H_W'(prod_ff[i][1])
                 + H_W'(prod_ff[i][2]) + H_W'(prod_ff[i][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         h_ff    <= h_in;
      end
   end

   assign h = h_ff;

endmodule
`default_nettype wire

FILE: rtl/pf_intr.sv
`default_nettype none
module pf_intr (
   input  logic             clock,
   input  logic             en,
   input  pf_pkg::hval_type h [4],
   input  logic [47:0]      intr [3],
   output pf_pkg::prep_type prep
);
   import pf_pkg::*;

   logic signed [KP_W-1:0] prod_ff [3][3];
   logic signed [KP_W-1:0] prod_in [3][3];
   logic signed [K_W-1:0]  k_ff [3];
   logic signed [K_W-1:0]  k_in [3];
   hval_type               w1_ff;
   hval_type               w2_ff;
   prep_type               prep_ff;
   prep_type               prep_in;

   always_comb begin
      coef_type c;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c = $signed(intr[i][16*j +: 16]);
            prod_in[i][j] = KP_W'(c) * KP_W'(h[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         k_in[i] = K_W'(prod_ff[i][0]) + K_W'(prod_ff[i][1]) + K_W'(prod_ff[i][2]);
      end
   end

   // magnitudes and signs for the dividers, depth test against 0.1
   always_comb begin
      logic [K_W-1:0]           mag_u;
      logic [K_W-1:0]           mag_v;
      logic signed [NEAR_W-1:0] d_ext;
      logic signed [NEAR_W-1:0] ten_d;
      logic signed [NEAR_W-1:0] w16;
      mag_u = k_ff[0][K_W-1] ? K_W'(-k_ff[0]) : K_W'(k_ff[0]);
      mag_v = k_ff[1][K_W-1] ? K_W'(-k_ff[1]) : K_W'(k_ff[1]);
      d_ext = NEAR_W'(k_ff[2]);
      ten_d = (d_ext <<< 3) + (d_ext <<< 1);
      w16   = NEAR_W'(w2_ff) <<< 4;
      prep_in.num_u  = {mag_u, 1'b0};
      prep_in.num_v  = {mag_v, 1'b0};
      prep_in.den    = k_ff[2][K_W-1] ? DEN_W'(-k_ff[2]) : DEN_W'(k_ff[2]);
      prep_in.neg_u  = k_ff[0][K_W-1] ^ k_ff[2][K_W-1];
      prep_in.neg_v  = k_ff[1][K_W-1] ^ k_ff[2][K_W-1];
      prep_in.dz     = (k_ff[2] == '0);
      prep_in.near   = w2_ff[H_W-1] ? (ten_d >= w16) : (ten_d <= w16);
      prep_in.zero_w = (w2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         w1_ff   <= h[3];
         k_ff    <= k_in;
         w2_ff   <= w1_ff;
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule
`default_nettype wire

FILE: rtl/pf_div.sv
`default_nettype none
module pf_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [pf_pkg::NUM_W-1:0]   num,
   input  logic [pf_pkg::DEN_W-1:0]   den,
   input  logic                       neg,
   input  logic                       zero,
   output pf_pkg::pix_type            pix
);
   import pf_pkg::*;

   // stage 0 tests overflow, stage s resolves quotient bit NSTEP-s
   logic [NUM_W-1:0] r_ff [NSTEP+1];
   logic [NUM_W-1:0] r_in [NSTEP+1];
   logic [NSTEP-1:0] t_ff [NSTEP+1];
   logic [NSTEP-1:0] t_in [NSTEP+1];
   logic [DEN_W-1:0] d_ff [NSTEP+1];
   logic             neg_ff [NSTEP+1];
   logic             zero_ff [NSTEP+1];
   logic             ovf_ff [NSTEP+1];
   logic             ovf0_in;
   pix_type          pix_ff;
   pix_type          pix_in;

   assign ovf0_in = CMP_W'(num) >= (CMP_W'(den) << NSTEP);

   always_comb begin
      logic [CMP_W-1:0] cmp;
      r_in[0] = num;
      t_in[0] = '0;
      for (int s = 1; s <= NSTEP; s++) begin
         cmp = CMP_W'(d_ff[s-1]) << (NSTEP - s);
         if (CMP_W'(r_ff[s-1]) >= cmp) begin
            r_in[s] = NUM_W'(CMP_W'(r_ff[s-1]) - cmp);
            t_in[s] = t_ff[s-1] | (NSTEP'(1) << (NSTEP - s));
         end else begin
            r_in[s] = r_ff[s-1];
            t_in[s] = t_ff[s-1];
         end
      end
   end

   // round half away from zero, then clamp to the signed pixel range
   always_comb begin
      logic [NSTEP:0] q;
      logic [NSTEP:0] lim;
      logic [NSTEP:0] sat;
      q   = ((NSTEP+1)'(t_ff[NSTEP]) + (NSTEP+1)'(1)) >> 1;
      lim = neg_ff[NSTEP] ? ((NSTEP+1)'(1) << (COORD_WIDTH - 1))
                          : ((NSTEP+1)'(1) << (COORD_WIDTH - 1)) - (NSTEP+1)'(1);
      sat = (ovf_ff[NSTEP] || (q > lim)) ? lim : q;
      if (zero_ff[NSTEP]) begin
         pix_in = '0;
      end else if (neg_ff[NSTEP]) begin
         pix_in = -$signed(sat[COORD_WIDTH-1:0]);
      end else begin
         pix_in = $signed(sat[COORD_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= r_in[0];
         t_ff[0]    <= t_in[0];
         d_ff[0]    <= den;
         neg_ff[0]  <= neg;
         zero_ff[0] <= zero;
         ovf_ff[0]  <= ovf0_in;
         for (int s = 1; s <= NSTEP; s++) begin
            r_ff[s]    <= r_in[s];
            t_ff[s]    <= t_in[s];
            d_ff[s]    <= d_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
         end
         pix_ff <= pix_in;
      end
   end

   assign pix = pix_ff;

endmodule
`default_nettype wire

FILE: rtl/lidar_point_box_projection_filter.sv
`default_nettype none
// Lidar point to camera box filter.
// Requests arrive on req_ (tdata: point_x, point_y, point_z, 16 bits each).
// Each request yields exactly one response on rsp_ carrying the verdict,
// the projected pixel column and row, and the original point.
// Configuration is written through csr_we / csr_addr / csr_wdata, one
// register per cycle, only while no request is in flight; the user must
// ensure this, the block itself does not enforce it.
// Pipeline from request accept to rsp_tvalid: two transform stages, three
// intrinsic stages, an overflow stage, one restoring-division stage per
// quotient bit, a rounding stage and the output register.
// Throughput: one point per cycle while the pipeline is not frozen; every
// stage, including each quotient bit of the two dividers, holds one point.
// Stall: the output register is backed by a one-entry skid buffer; the
// pipeline freezes only once the skid buffer holds a response, and
// req_tready drops in that case. Nothing is lost or repeated.
// Reset: synchronous; clears all valid bits, loads identity matrices and
// an empty box.
module lidar_point_box_projection_filter (
   input  logic                      clock,
   input  logic                      reset,
   // point_x [15:0], point_y [31:16], point_z [47:32]
   input  logic [pf_pkg::REQ_W-1:0]  req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // verdict, pixel_u, pixel_v, kept_x, kept_y, kept_z, zero padding
   output logic [pf_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_we,
   input  logic [2:0]                csr_addr,
   input  logic [63:0]               csr_wdata
);
   import pf_pkg::*;

   localparam int FLAG_POS = XF_LAT + IN_LAT;

   logic [63:0]      ext_ff [4];
   logic [47:0]      intr_ff [3];
   logic [63:0]      box_ff;

   logic             en;
   coord_type        pt [3];
   hval_type         h [4];
   prep_type         prep;
   pix_type          pix_u;
   pix_type          pix_v;

   logic             valid_ff [PIPE_LAT];
   side_type         side_ff [PIPE_LAT];
   side_type         side_in [PIPE_LAT];

   logic [RSP_W-1:0] result;
   logic             push;
   logic             take;
   logic [RSP_W-1:0] out_data_ff;
   logic             out_valid_ff;
   logic [RSP_W-1:0] skid_data_ff;
   logic             skid_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff[0]  <= 64'd4096;
         ext_ff[1]  <= 64'd268435456;
         ext_ff[2]  <= 64'd17592186044416;
         ext_ff[3]  <= 64'd1152921504606846976;
         intr_ff[0] <= 48'd16;
         intr_ff[1] <= 48'd1048576;
         intr_ff[2] <= 48'd68719476736;
         box_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_EXT0: ext_ff[0]  <= csr_wdata;
            CSR_EXT1: ext_ff[1]  <= csr_wdata;
            CSR_EXT2: ext_ff[2]  <= csr_wdata;
            CSR_EXT3: ext_ff[3]  <= csr_wdata;
            CSR_INT0: intr_ff[0] <= csr_wdata[47:0];
            CSR_INT1: intr_ff[1] <= csr_wdata[47:0];
            CSR_INT2: intr_ff[2] <= csr_wdata[47:0];
            CSR_BOX:  box_ff     <= csr_wdata;
            default:  box_ff     <= box_ff;
         endcase
      end
   end

   // advance the whole pipeline while the skid buffer is free
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign pt[0] = $signed(req_tdata[15:0]);
   assign pt[1] = $signed(req_tdata[31:16]);
   assign pt[2] = $signed(req_tdata[47:32]);

   pf_xform u_xform (
      .clock (clock),
      .en    (en),
      .pt    (pt),
      .ext   (ext_ff),
      .h     (h)
   );

   pf_intr u_intr (
      .clock (clock),
      .en    (en),
      .h     (h),
      .intr  (intr_ff),
      .prep  (prep)
   );

   pf_div u_div_u (
      .clock (clock),
      .en    (en),
      .num   (prep.num_u),
      .den   (prep.den),
      .neg   (prep.neg_u),
      .zero  (prep.dz),
      .pix   (pix_u)
   );

   pf_div u_div_v (
      .clock (clock),
      .en    (en),
      .num   (prep.num_v),
      .den   (prep.den),
      .neg   (prep.neg_v),
      .zero  (prep.dz),
      .pix   (pix_v)
   );

   // sideband line: point and flags travel beside the arithmetic;
   // merge the depth and weight flags once the intrinsic stage has them
   always_comb begin
      side_in[0].behind = pt[0][PT_W-1];
      side_in[0].zero_w = 1'b0;
      side_in[0].near   = 1'b0;
      side_in[0].x      = pt[0];
      side_in[0].y      = pt[1];
      side_in[0].z      = pt[2];
      for (int i = 1; i < PIPE_LAT; i++) begin
         side_in[i] = side_ff[i-1];
         if (i == FLAG_POS) begin
            side_in[i].zero_w = prep.zero_w;
            side_in[i].near   = prep.near;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
      end
   end

   // final verdict: behind, zero weight, near, then the half-open box test
   always_comb begin
      side_type                side;
      verdict_type             verdict;
      pix_type                 ou;
      pix_type                 ov;
      logic signed [BOX_W-1:0] ux;
      logic signed [BOX_W-1:0] vx;
      logic signed [BOX_W-1:0] left;
      logic signed [BOX_W-1:0] top;
      logic signed [BOX_W-1:0] right;
      logic signed [BOX_W-1:0] bottom;
      side   = side_ff[PIPE_LAT-1];
      ux     = BOX_W'(pix_u);
      vx     = BOX_W'(pix_v);
      left   = $signed(BOX_W'(box_ff[15:0]));
      top    = $signed(BOX_W'(box_ff[31:16]));
      right  = left + $signed(BOX_W'(box_ff[47:32]));
      bottom = top + $signed(BOX_W'(box_ff[63:48]));
      ou     = pix_u;
      ov     = pix_v;
      if (side.behind) begin
         verdict = V_BEHIND;
         ou      = '0;
         ov      = '0;
      end else if (side.zero_w) begin
         verdict = V_ZERO_W;
         ou      = '0;
         ov      = '0;
      end else if (side.near) begin
         verdict = V_NEAR;
      end else if (ux >= left && ux < right && vx >= top && vx < bottom) begin
         verdict = V_INSIDE;
      end else begin
         verdict = V_OUTSIDE;
      end
      result = RSP_W'({side.z, side.y, side.x, ov, ou, verdict});
   end

   assign push = en && valid_ff[PIPE_LAT-1];
   assign take = out_valid_ff && rsp_tready;

   // output register with skid buffer: park a result while the output waits
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end else if (push) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire
